// ===== hw/rtl/msplim_pkg.sv =====
// shared types, widths and constants of the motor stall power limiter
package msplim_pkg;

  // window geometry
  localparam int WINDOW_LENGTH = 8;
  localparam int SAMPLE_W      = 16;
  localparam int POWER_W       = 16;
  localparam int ENC_W         = 32;

  // register field widths
  localparam int CFG_SPEED_W = 20;
  localparam int CFG_POWER_W = 19;

  // output widths
  localparam int DRIVE_W   = 15;
  localparam int SUM_OUT_W = 19;
  localparam int STATUS_W  = 2;

  // exact sum widths, never narrower than the output field
  localparam int SPEED_NEED_W = $clog2(WINDOW_LENGTH * 65535 + 1);
  localparam int POWER_NEED_W = $clog2(WINDOW_LENGTH * 32768 + 1);
  localparam int SPEED_SUM_W  = (SPEED_NEED_W > SUM_OUT_W) ? SPEED_NEED_W : SUM_OUT_W;
  localparam int POWER_SUM_W  = (POWER_NEED_W > SUM_OUT_W) ? POWER_NEED_W : SUM_OUT_W;

  // comparison widths
  localparam int SPEED_CMP_W = (SPEED_SUM_W > CFG_SPEED_W) ? SPEED_SUM_W : CFG_SPEED_W;
  localparam int POWER_CMP_W = (POWER_SUM_W > CFG_POWER_W) ? POWER_SUM_W : CFG_POWER_W;

  // saturation and clamp constants
  localparam int SUM_OUT_MAX   = 524287;
  localparam int PARTIAL_CLAMP = 2000;
  localparam int FULL_CLAMP    = 12000;

  // register map
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam logic [1:0] REG_SLOW_SPEED    = 2'd0;
  localparam logic [1:0] REG_STALL_POWER   = 2'd1;
  localparam logic [1:0] REG_STOPPED_SPEED = 2'd2;
  localparam logic [1:0] REG_CUT_POWER     = 2'd3;

  // reset values of the registers
  localparam logic [CFG_SPEED_W-1:0] SLOW_SPEED_RST    = 20'd24;
  localparam logic [CFG_POWER_W-1:0] STALL_POWER_RST   = 19'd38400;
  localparam logic [CFG_SPEED_W-1:0] STOPPED_SPEED_RST = 20'd5;
  localparam logic [CFG_POWER_W-1:0] CUT_POWER_RST     = 19'd24000;

  // limit status codes
  localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CLAMP = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CUT   = 2'd2;

  // one window entry: speed sample and absolute power
  typedef struct packed {
    logic [SAMPLE_W-1:0] speed;
    logic [SAMPLE_W-1:0] power;
  } sample_t;

  // threshold registers as seen by the limiter
  typedef struct packed {
    logic [CFG_SPEED_W-1:0] slow_speed;
    logic [CFG_POWER_W-1:0] stall_power;
    logic [CFG_SPEED_W-1:0] stopped_speed;
    logic [CFG_POWER_W-1:0] cut_power;
  } limits_t;

endpackage

// ===== hw/rtl/msplim_cell.sv =====
// one window cell: holds a speed and power entry and passes it down the chain
module msplim_cell
  import msplim_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    shift_en,
  input  sample_t sample_in,
  output sample_t sample_out
);

  sample_t entry_r;

  // take the neighbor's entry on each shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else if (shift_en) begin
      entry_r <= sample_in;
    end
  end

  assign sample_out = entry_r;

endmodule

// ===== hw/rtl/msplim_limiter.sv =====
// output stage: stall thresholds, power clamps and the result register
module msplim_limiter
  import msplim_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  logic                      src_valid,
  input  limits_t                   limits,
  input  logic [SPEED_SUM_W-1:0]    speed_sum,
  input  logic [POWER_SUM_W-1:0]    power_sum,
  input  logic signed [POWER_W-1:0] power,
  output logic                      res_valid,
  output logic signed [DRIVE_W-1:0] drive_power,
  output logic [SUM_OUT_W-1:0]      speed_sum_out,
  output logic [SUM_OUT_W-1:0]      power_sum_out,
  output logic [STATUS_W-1:0]       limit_status
);

  localparam logic signed [POWER_W-1:0] PART_HI = POWER_W'(PARTIAL_CLAMP);
  localparam logic signed [POWER_W-1:0] PART_LO = POWER_W'(-PARTIAL_CLAMP);
  localparam logic signed [POWER_W-1:0] FULL_HI = POWER_W'(FULL_CLAMP);
  localparam logic signed [POWER_W-1:0] FULL_LO = POWER_W'(-FULL_CLAMP);

  logic                      valid_r;
  logic signed [DRIVE_W-1:0] drive_r, drive_nxt;
  logic [SUM_OUT_W-1:0]      speed_out_r, speed_out_nxt;
  logic [SUM_OUT_W-1:0]      power_out_r, power_out_nxt;
  logic [STATUS_W-1:0]       status_r, status_nxt;
  logic                      partial, cut;
  logic signed [POWER_W-1:0] hi, lo, limited;

  // threshold tests on the exact sums
  always_comb begin
    partial = (SPEED_CMP_W'(speed_sum) < SPEED_CMP_W'(limits.slow_speed)) &&
              (POWER_CMP_W'(power_sum) > POWER_CMP_W'(limits.stall_power));
    cut     = (SPEED_CMP_W'(speed_sum) < SPEED_CMP_W'(limits.stopped_speed)) &&
              (POWER_CMP_W'(power_sum) > POWER_CMP_W'(limits.cut_power));
  end

  // clamp; cut to zero wins over the partial clamp
  always_comb begin
    hi = partial ? PART_HI : FULL_HI;
    lo = partial ? PART_LO : FULL_LO;
    if (cut) begin
      limited    = '0;
      status_nxt = STATUS_CUT;
    end else begin
      if (power > hi) begin
        limited = hi;
      end else if (power < lo) begin
        limited = lo;
      end else begin
        limited = power;
      end
      status_nxt = partial ? STATUS_CLAMP : STATUS_NONE;
    end
    drive_nxt = DRIVE_W'(limited);
  end

  // saturate the reported sums
  always_comb begin
    speed_out_nxt = (speed_sum > SPEED_SUM_W'(SUM_OUT_MAX)) ? SUM_OUT_W'(SUM_OUT_MAX)
                                                            : speed_sum[SUM_OUT_W-1:0];
    power_out_nxt = (power_sum > POWER_SUM_W'(SUM_OUT_MAX)) ? SUM_OUT_W'(SUM_OUT_MAX)
                                                            : power_sum[SUM_OUT_W-1:0];
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= src_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      drive_r     <= drive_nxt;
      speed_out_r <= speed_out_nxt;
      power_out_r <= power_out_nxt;
      status_r    <= status_nxt;
    end
  end

  assign res_valid     = valid_r;
  assign drive_power   = drive_r;
  assign speed_sum_out = speed_out_r;
  assign power_sum_out = power_out_r;
  assign limit_status  = status_r;

endmodule

// ===== hw/rtl/motor_stall_power_limiter_unit.sv =====
// top level of the motor stall power limiter: sample stage, cell chain, sums, registers
// Takes one request per clock while in_stall is low and returns one result per request.
// The three register stages (speed and power sample, window shift with running sums,
// limiter and result register) each hold one request, so a new request enters every
// cycle while earlier ones are in flight, unless the result side stalls with every stage
// full, and a finished result waits in the output register. The window is a chain of
// eight cells, one sample pair each, shifted once per request; the sums are kept by
// adding the newest sample and subtracting the one leaving the last cell. The user must
// write thresholds over the register port only while no request is in flight; the block
// itself does not enforce this.
module motor_stall_power_limiter_unit
  import msplim_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [POWER_W-1:0] in_requested_power,
  input  logic signed [ENC_W-1:0]   in_encoder_count,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DRIVE_W-1:0] out_drive_power,
  output logic [SUM_OUT_W-1:0]      out_speed_sum,
  output logic [SUM_OUT_W-1:0]      out_power_sum,
  output logic [STATUS_W-1:0]       out_limit_status,
  // register port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  limits_t                   limits_r;
  logic                      cfg_wr;
  logic [1:0]                cfg_idx;

  logic                      in_acc;
  logic                      s1_can, out_load, s1_en;
  logic                      s0_v_r, s1_v_r;

  logic signed [ENC_W-1:0]   prev_count_r;
  logic signed [ENC_W:0]     diff_up, diff_dn, adiff;
  logic [SAMPLE_W-1:0]       speed_smp, power_smp;

  sample_t                   sample_r;
  logic signed [POWER_W-1:0] s0_power_r, s1_power_r;
  sample_t                   link [WINDOW_LENGTH+1];

  logic [SPEED_SUM_W-1:0]    speed_sum_r, speed_sum_nxt;
  logic [POWER_SUM_W-1:0]    power_sum_r, power_sum_nxt;

  // register writes
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.slow_speed    <= SLOW_SPEED_RST;
      limits_r.stall_power   <= STALL_POWER_RST;
      limits_r.stopped_speed <= STOPPED_SPEED_RST;
      limits_r.cut_power     <= CUT_POWER_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SLOW_SPEED:    limits_r.slow_speed    <= pwdata[CFG_SPEED_W-1:0];
        REG_STALL_POWER:   limits_r.stall_power   <= pwdata[CFG_POWER_W-1:0];
        REG_STOPPED_SPEED: limits_r.stopped_speed <= pwdata[CFG_SPEED_W-1:0];
        REG_CUT_POWER:     limits_r.cut_power     <= pwdata[CFG_POWER_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (cfg_idx)
      REG_SLOW_SPEED:    prdata = DATA_W'(limits_r.slow_speed);
      REG_STALL_POWER:   prdata = DATA_W'(limits_r.stall_power);
      REG_STOPPED_SPEED: prdata = DATA_W'(limits_r.stopped_speed);
      REG_CUT_POWER:     prdata = DATA_W'(limits_r.cut_power);
      default:           prdata = '0;
    endcase
  end

  // pipeline flow control
  assign out_load = !out_valid || !out_stall;
  assign s1_can   = !s1_v_r || out_load;
  assign s1_en    = s0_v_r && s1_can;
  assign in_stall = s0_v_r && !s1_can;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s0_v_r <= in_valid;
      end
      if (s1_can) begin
        s1_v_r <= s0_v_r;
      end
    end
  end

  // speed sample: exact 33-bit difference, absolute value, saturated
  always_comb begin
    diff_up   = (ENC_W+1)'(in_encoder_count) - (ENC_W+1)'(prev_count_r);
    diff_dn   = (ENC_W+1)'(prev_count_r) - (ENC_W+1)'(in_encoder_count);
    adiff     = diff_up[ENC_W] ? diff_dn : diff_up;
    speed_smp = (|adiff[ENC_W:SAMPLE_W]) ? {SAMPLE_W{1'b1}} : adiff[SAMPLE_W-1:0];
    power_smp = in_requested_power[POWER_W-1] ? SAMPLE_W'(-in_requested_power)
                                              : SAMPLE_W'(in_requested_power);
  end

  // previous encoder reading
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_count_r <= '0;
    end else if (in_acc) begin
      prev_count_r <= in_encoder_count;
    end
  end

  // sample stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r.speed <= speed_smp;
      sample_r.power <= power_smp;
      s0_power_r     <= in_requested_power;
    end
  end

  // cell chain: newest enters at the top, oldest leaves from cell zero
  assign link[WINDOW_LENGTH] = sample_r;

  for (genvar i = 0; i < WINDOW_LENGTH; i++) begin : g_cell
    msplim_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (s1_en),
      .sample_in (link[i+1]),
      .sample_out(link[i])
    );
  end

  // running sums: add the newest, drop the oldest
  always_comb begin
    speed_sum_nxt = speed_sum_r + SPEED_SUM_W'(sample_r.speed) - SPEED_SUM_W'(link[0].speed);
    power_sum_nxt = power_sum_r + POWER_SUM_W'(sample_r.power) - POWER_SUM_W'(link[0].power);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_sum_r <= '0;
      power_sum_r <= '0;
    end else if (s1_en) begin
      speed_sum_r <= speed_sum_nxt;
      power_sum_r <= power_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_power_r <= s0_power_r;
    end
  end

  // limiter and result register
  msplim_limiter u_limiter (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (out_load),
    .src_valid    (s1_v_r),
    .limits       (limits_r),
    .speed_sum    (speed_sum_r),
    .power_sum    (power_sum_r),
    .power        (s1_power_r),
    .res_valid    (out_valid),
    .drive_power  (out_drive_power),
    .speed_sum_out(out_speed_sum),
    .power_sum_out(out_power_sum),
    .limit_status (out_limit_status)
  );

`ifndef ASSERT_OFF
  // requests are held back only when every stage is full and the output is stalled
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s0_v_r && s1_v_r && out_valid && out_stall))
    else $error("request stalled while the pipeline has room");

  // the sums move only with a window shift
  a_sums_follow_shift: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_en |=> ($stable(speed_sum_r) && $stable(power_sum_r)))
    else $error("running sums changed without a window shift");

  // a cut result carries zero power
  a_cut_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_limit_status == STATUS_CUT) |-> (out_drive_power == '0))
    else $error("cut result with nonzero power");

  // a clamped result stays within the partial clamp
  a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_limit_status == STATUS_CLAMP) |->
      (out_drive_power <= DRIVE_W'(PARTIAL_CLAMP) &&
       out_drive_power >= DRIVE_W'(-PARTIAL_CLAMP)))
    else $error("clamped result outside the partial clamp");
`endif

endmodule

// ===== tb/tb_motor_stall_power_limiter_unit.sv =====
// testbench of the motor stall power limiter: directed and random requests against a predictor
`timescale 1ns / 1ps

module tb_motor_stall_power_limiter_unit;
  import msplim_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic signed [POWER_W-1:0] power;
    logic signed [ENC_W-1:0]   count;
  } power_request_t;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic [SUM_OUT_W-1:0]      speed_sum;
    logic [SUM_OUT_W-1:0]      power_sum;
    logic [STATUS_W-1:0]       status;
  } drive_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [POWER_W-1:0] in_requested_power = '0;
  logic signed [ENC_W-1:0]   in_encoder_count = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [DRIVE_W-1:0] out_drive_power;
  logic [SUM_OUT_W-1:0]      out_speed_sum;
  logic [SUM_OUT_W-1:0]      out_power_sum;
  logic [STATUS_W-1:0]       out_limit_status;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  motor_stall_power_limiter_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_requested_power (in_requested_power),
    .in_encoder_count   (in_encoder_count),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_drive_power    (out_drive_power),
    .out_speed_sum      (out_speed_sum),
    .out_power_sum      (out_power_sum),
    .out_limit_status   (out_limit_status),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // clock and the single reset
  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // requests waiting to be driven and results still owed by the block
  power_request_t pending_requests[$];
  drive_result_t  due_results[$];
  int             errors = 0;

  // predictor copy of the thresholds and the window state
  logic [CFG_SPEED_W-1:0] lim_slow_speed    = SLOW_SPEED_RST;
  logic [CFG_POWER_W-1:0] lim_stall_power   = STALL_POWER_RST;
  logic [CFG_SPEED_W-1:0] lim_stopped_speed = STOPPED_SPEED_RST;
  logic [CFG_POWER_W-1:0] lim_cut_power     = CUT_POWER_RST;
  logic [SAMPLE_W-1:0]    speed_hist[WINDOW_LENGTH];
  logic [SAMPLE_W-1:0]    power_hist[WINDOW_LENGTH];
  logic signed [ENC_W-1:0] last_count = '0;

  initial begin
    for (int i = 0; i < WINDOW_LENGTH; i++) begin
      speed_hist[i] = '0;
      power_hist[i] = '0;
    end
  end

  // one tick of the limiter: window update, sums, stall limits, final clamp
  function automatic drive_result_t limit_drive_power(input logic signed [POWER_W-1:0] power,
                                                      input logic signed [ENC_W-1:0] count);
    logic [ENC_W:0] delta;
    logic [ENC_W:0] travel;
    logic [SAMPLE_W-1:0] speed;
    int p;
    int apower;
    int speed_total;
    int power_total;
    logic clamp_hit;
    logic cut_hit;
    drive_result_t r;
    // exact 33-bit difference, magnitude saturated to one sample
    delta = {count[ENC_W-1], count} - {last_count[ENC_W-1], last_count};
    travel = delta[ENC_W] ? -delta : delta;
    speed = (travel > 65535) ? 16'hFFFF : travel[SAMPLE_W-1:0];
    p = int'(power);
    apower = (p < 0) ? -p : p;
    last_count = count;
    // slide the windows and sum them
    for (int i = 0; i < WINDOW_LENGTH - 1; i++) begin
      speed_hist[i] = speed_hist[i+1];
      power_hist[i] = power_hist[i+1];
    end
    speed_hist[WINDOW_LENGTH-1] = speed;
    power_hist[WINDOW_LENGTH-1] = apower[SAMPLE_W-1:0];
    speed_total = 0;
    power_total = 0;
    for (int i = 0; i < WINDOW_LENGTH; i++) begin
      speed_total += int'(speed_hist[i]);
      power_total += int'(power_hist[i]);
    end
    // stall limits, cut to zero wins over the partial clamp
    clamp_hit = (speed_total < int'(lim_slow_speed)) && (power_total > int'(lim_stall_power));
    cut_hit = (speed_total < int'(lim_stopped_speed)) && (power_total > int'(lim_cut_power));
    r.status = STATUS_NONE;
    if (clamp_hit) begin
      if (p > PARTIAL_CLAMP) p = PARTIAL_CLAMP;
      if (p < -PARTIAL_CLAMP) p = -PARTIAL_CLAMP;
      r.status = STATUS_CLAMP;
    end
    if (cut_hit) begin
      p = 0;
      r.status = STATUS_CUT;
    end
    if (p > FULL_CLAMP) p = FULL_CLAMP;
    if (p < -FULL_CLAMP) p = -FULL_CLAMP;
    r.drive = p[DRIVE_W-1:0];
    r.speed_sum = SUM_OUT_W'((speed_total > SUM_OUT_MAX) ? SUM_OUT_MAX : speed_total);
    r.power_sum = SUM_OUT_W'((power_total > SUM_OUT_MAX) ? SUM_OUT_MAX : power_total);
    return r;
  endfunction

  // driver: bursts of requests with random gaps, predicting on acceptance
  int burst_left = 0;
  int gap_left = 0;
  power_request_t next_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(limit_drive_power(in_requested_power, in_encoder_count));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          next_req = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_requested_power <= next_req.power;
          in_encoder_count <= next_req.count;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // field compare
  function automatic void check_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      errors++;
      $error("%s expected %0d actual %0d", name, expv, actv);
    end
  endfunction

  // monitor: compares results and drives the result stall pattern
  int results_seen = 0;
  int next_hold_at = 300;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  drive_result_t owed;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          errors++;
          $error("result with no request outstanding");
        end else begin
          owed = due_results.pop_front();
          check_field("drive_power", int'(owed.drive), int'(out_drive_power));
          check_field("speed_sum", int'(owed.speed_sum), int'(out_speed_sum));
          check_field("power_sum", int'(owed.power_sum), int'(out_power_sum));
          check_field("limit_status", int'(owed.status), int'(out_limit_status));
        end
      end
      // long hold-off now and then so the pipeline backs up into the input
      if (hold_left == 0 && results_seen >= next_hold_at) begin
        hold_left = HOLD_CYCLES;
        next_hold_at += 800;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // watchdog on cycles with no handshake on any port
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (psel && penable && pwrite && pready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("motor_stall_power_limiter_unit regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // register write: setup cycle, then access until pready
  task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_SLOW_SPEED:    lim_slow_speed = value[CFG_SPEED_W-1:0];
      REG_STALL_POWER:   lim_stall_power = value[CFG_POWER_W-1:0];
      REG_STOPPED_SPEED: lim_stopped_speed = value[CFG_SPEED_W-1:0];
      default:           lim_cut_power = value[CFG_POWER_W-1:0];
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_limits(input logic [DATA_W-1:0] slow, input logic [DATA_W-1:0] stall,
                            input logic [DATA_W-1:0] stopped, input logic [DATA_W-1:0] cut);
    cfg_write(REG_SLOW_SPEED, slow);
    cfg_write(REG_STALL_POWER, stall);
    cfg_write(REG_STOPPED_SPEED, stopped);
    cfg_write(REG_CUT_POWER, cut);
  endtask

  // wait until every request is driven and every result is back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || due_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  logic signed [ENC_W-1:0] gen_count = '0;

  task automatic add_request(input logic signed [POWER_W-1:0] power,
                             input logic signed [ENC_W-1:0] count);
    power_request_t r;
    r.power = power;
    r.count = count;
    pending_requests.push_back(r);
    gen_count = count;
  endtask

  int power_corners[12] = '{-32768, 32767, 0, 1, -1, 2000, -2000, 2001, -2001,
                            12000, -12000, 12001};

  function automatic logic signed [POWER_W-1:0] random_power();
    int kind;
    int mag;
    kind = $urandom_range(0, 9);
    if (kind < 3) return POWER_W'($urandom);
    if (kind < 7) begin
      mag = $urandom_range(8000, 32768);
      return POWER_W'(($urandom_range(0, 1) != 0) ? -mag : mag);
    end
    if (kind < 9) return POWER_W'(int'($urandom_range(0, 6000)) - 3000);
    return POWER_W'(power_corners[$urandom_range(0, 11)]);
  endfunction

  // segments of stopped, creeping, moving and noisy encoder motion
  task automatic add_random_requests(input int n);
    int seg_left;
    int motion;
    int step;
    seg_left = 0;
    motion = 0;
    for (int i = 0; i < n; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(4, 40);
        step = $urandom_range(0, 19);
        motion = (step < 6) ? 0 : (step < 12) ? 1 : (step < 17) ? 2 : 3;
      end
      seg_left--;
      case (motion)
        0: step = int'($urandom_range(0, 2)) - 1;
        1: step = int'($urandom_range(0, 12)) - 6;
        2: step = int'($urandom_range(0, 10000)) - 5000;
        default: step = 0;
      endcase
      if (motion == 3) add_request(random_power(), ENC_W'($urandom));
      else add_request(random_power(), gen_count + step);
    end
  endtask

  // stimulus sequence
  initial begin
    @(posedge rst_n);
    // first tick against a zero count, power extremes, big encoder jumps
    add_request(16'sd100, 32'sd7);
    add_request(-16'sd32768, 32'sd7);
    add_request(16'sd32767, 32'sh7FFFFFFF);
    add_request(16'sd0, 32'sh80000000);
    add_request(-16'sd1, 32'sh80000003);
    // stopped motor under full power: cut to zero
    for (int i = 0; i < 9; i++) begin
      add_request((i % 2 == 0) ? 16'sd32767 : -16'sd32768, 32'sh80000003);
    end
    // creeping motor under high power: clamp to the partial limit
    for (int i = 0; i < 8; i++) begin
      add_request((i % 2 == 0) ? -16'sd20000 : 16'sd2001, gen_count + 1);
    end
    add_request(16'sd12001, gen_count + 20);
    add_request(-16'sd12001, gen_count + 20);
    add_request(-16'sd32768, gen_count - 65536);
    add_random_requests(200);
    wait_drained();

    set_limits('0, '0, '0, '0);
    add_random_requests(150);
    wait_drained();

    set_limits('1, '1, '1, '1);
    add_random_requests(150);
    wait_drained();

    set_limits(524288, 262144, 524288, 262144);
    add_random_requests(150);
    wait_drained();

    repeat (6) begin
      if ($urandom_range(0, 3) == 0) begin
        set_limits($urandom, $urandom, $urandom, $urandom);
      end else begin
        int stopped;
        stopped = $urandom_range(0, 12);
        set_limits($urandom_range(stopped, 300), $urandom_range(0, 150000), stopped,
                   $urandom_range(0, 150000));
      end
      add_random_requests(170);
      wait_drained();
    end

    if (due_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("motor_stall_power_limiter_unit regression: pass");
    end else begin
      $display("motor_stall_power_limiter_unit regression: fail");
    end
    $finish;
  end

endmodule
